@@ rtl/esb_pkg.sv @@
// ----------------------------------------------------------------------------
// esb_pkg: shared types for the exchange sort buffer
// Request and result payloads, and the compare-exchange result bundle.
// ----------------------------------------------------------------------------
package esb_pkg;

	localparam int DATA_W = 32;

	typedef struct packed {
		logic signed [DATA_W-1:0] item_value;
		logic                     is_last;
	} req_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] sorted_value;
		logic                     end_of_set;
		logic                     dropped;
	} res_t;

	// Outcome of one compare-exchange step.
	typedef struct packed {
		logic                     swap;
		logic signed [DATA_W-1:0] keep;
		logic signed [DATA_W-1:0] give;
	} cx_t;

endpackage

@@ rtl/esb_cmp_swap.sv @@
// ----------------------------------------------------------------------------
// esb_cmp_swap: compare-exchange unit
// Signed compare of the held value against a candidate; keep the smaller.
// ----------------------------------------------------------------------------
module esb_cmp_swap import esb_pkg::*; (
	input  logic signed [DATA_W-1:0] held,
	input  logic signed [DATA_W-1:0] cand,
	output cx_t                      cx
);

	always_comb begin
		cx.swap = held > cand;
		cx.keep = cx.swap ? cand : held;
		cx.give = cx.swap ? held : cand;
	end

endmodule

@@ rtl/exchange_sort_buffer.sv @@
// ----------------------------------------------------------------------------
// exchange_sort_buffer: collect a set of signed values, sort, stream out
// Loading: one request per cycle while idle; start is ignored while busy.
//   After the last request the set is sorted in place, one position per
//   pass, at a pace set by the single compare-exchange unit and the one
//   read port of the store. Each settled position is shown as a result.
// A new set is taken only once busy drops; results cannot be stalled.
// Reset: arst_n clears the sequencer, fill count and drop flag at once;
//   store contents stay undefined until written.
// ----------------------------------------------------------------------------
module exchange_sort_buffer import esb_pkg::*; #(
	parameter int MAX_ITEMS = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  req_t request,
	output logic result_valid,
	output res_t result
);

	localparam int CW = $clog2(MAX_ITEMS + 1);
	localparam int IW = $clog2(MAX_ITEMS);

	typedef enum logic [1:0] {
		ST_IDLE,   // take requests, append to the store
		ST_FETCH,  // issue read of position i
		ST_HEAD,   // latch position i, start its scan
		ST_SCAN    // compare-exchange position i with j, one j per cycle
	} state_t;

	state_t                  state_q;
	logic [CW-1:0]           count_q;   // values held in the open set
	logic                    ovf_q;     // a value of the open set was dropped
	logic [IW-1:0]           i_q;       // position being settled
	logic [IW-1:0]           j_q;       // later position under compare
	logic signed [DATA_W-1:0] cur_q;    // running minimum for position i
	logic                    res_valid_q;
	res_t                    res_q;

	// Store: one write port, one registered read port.
	logic signed [DATA_W-1:0] mem [MAX_ITEMS];
	logic signed [DATA_W-1:0] rd_data_q;
	logic [IW-1:0]           rd_addr;
	logic [IW-1:0]           wr_addr;
	logic signed [DATA_W-1:0] wr_data;
	logic                    wr_en;

	logic                    room;
	logic [IW-1:0]           last_idx;
	cx_t                     cx;

	assign busy         = state_q != ST_IDLE;
	assign result_valid = res_valid_q;
	assign result       = res_q;

	assign room     = count_q < CW'(MAX_ITEMS);
	assign last_idx = IW'(count_q - CW'(1));

	esb_cmp_swap u_cmp (
		.held (cur_q),
		.cand (rd_data_q),
		.cx   (cx)
	);

	// Read address: position i, then the walk of j over later positions.
	always_comb begin
		case (state_q)
			ST_FETCH: rd_addr = i_q;
			ST_HEAD:  rd_addr = i_q + IW'(1);
			ST_SCAN:  rd_addr = j_q + IW'(1);
			default:  rd_addr = i_q;
		endcase
	end

	// Write port: append on a request, or push the larger value back to j.
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = j_q;
		wr_data = cx.give;
		if (state_q == ST_IDLE) begin
			wr_en   = start && room;
			wr_addr = IW'(count_q);
			wr_data = request.item_value;
		end else if (state_q == ST_SCAN) begin
			wr_en = cx.swap;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			ovf_q       <= 1'b0;
			i_q         <= '0;
			j_q         <= '0;
			res_valid_q <= 1'b0;
		end else begin
			res_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						// Append while there is room; otherwise drop and flag.
						if (room) begin
							count_q <= count_q + CW'(1);
						end else begin
							ovf_q <= 1'b1;
						end
						if (request.is_last) begin
							i_q     <= '0;
							state_q <= ST_FETCH;
						end
					end
				end
				ST_FETCH: begin
					state_q <= ST_HEAD;
				end
				ST_HEAD: begin
					if (i_q == last_idx) begin
						// Final position needs no scan: emit it and close the set.
						res_valid_q       <= 1'b1;
						res_q.sorted_value <= rd_data_q;
						res_q.end_of_set   <= 1'b1;
						res_q.dropped      <= ovf_q;
						count_q           <= '0;
						ovf_q             <= 1'b0;
						state_q           <= ST_IDLE;
					end else begin
						cur_q   <= rd_data_q;
						j_q     <= i_q + IW'(1);
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					cur_q <= cx.keep;
					if (j_q == last_idx) begin
						// Position i is settled: later passes never touch it.
						res_valid_q       <= 1'b1;
						res_q.sorted_value <= cx.keep;
						res_q.end_of_set   <= 1'b0;
						res_q.dropped      <= ovf_q;
						i_q               <= i_q + IW'(1);
						state_q           <= ST_FETCH;
					end else begin
						j_q <= j_q + IW'(1);
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	a_res_from_sort: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> $past(busy))
		else $error("result shown without a sort in progress");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_ITEMS))
		else $error("fill count beyond capacity");

	a_scan_order: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SCAN |-> j_q > i_q && j_q <= last_idx)
		else $error("scan index out of order");

	a_sort_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> count_q != '0)
		else $error("sorting an empty set");

	a_set_closed: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.end_of_set |-> !busy && count_q == '0 && !ovf_q)
		else $error("set not cleared after its final result");
`endif

endmodule

@@ test/exchange_sort_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// exchange_sort_checker: result predictor and scoreboard for the sort buffer
// Mirrors the fill count, drop flag and value store of the block. On each
// closing request it sorts the held set ascending and queues the expected
// stream. Each strobed result is then compared with the oldest queued value.
// ----------------------------------------------------------------------------
module exchange_sort_checker import esb_pkg::*; #(
	parameter int MAX_ITEMS = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic busy,
	input  req_t request,
	input  logic result_valid,
	input  res_t result,
	output int   fail_count,
	output int   pending,
	output int   sets_closed,
	output int   sets_dropped,
	output int   values_checked
);

	localparam int PRINT_CAP = 40;

	logic signed [DATA_W-1:0] held_values [MAX_ITEMS];
	int                       held_count;
	logic                     overflow_seen;
	res_t                     sorted_q [$];

	initial begin
		fail_count     = 0;
		sets_closed    = 0;
		sets_dropped   = 0;
		values_checked = 0;
		held_count     = 0;
		overflow_seen  = 1'b0;
	end

	// Print only the first few lines, but count every mismatch.
	task automatic report_mismatch(input string msg);
		if (fail_count < PRINT_CAP)
			$display("%0t: MISMATCH %s", $time, msg);
		fail_count++;
	endtask

	task automatic sort_and_queue();
		logic signed [DATA_W-1:0] work [MAX_ITEMS];
		logic signed [DATA_W-1:0] swap_tmp;
		res_t                     want;
		work = held_values;
		for (int i = 0; i < held_count; i++)
			for (int j = i + 1; j < held_count; j++)
				if (work[i] > work[j]) begin
					swap_tmp = work[i];
					work[i]  = work[j];
					work[j]  = swap_tmp;
				end
		for (int k = 0; k < held_count; k++) begin
			want.sorted_value = work[k];
			want.end_of_set   = (k == held_count - 1);
			want.dropped      = overflow_seen;
			sorted_q.push_back(want);
		end
		sets_closed++;
		if (overflow_seen)
			sets_dropped++;
		held_count    = 0;
		overflow_seen = 1'b0;
	endtask

	task automatic take_request(input req_t req);
		if (held_count < MAX_ITEMS) begin
			held_values[held_count] = req.item_value;
			held_count++;
		end else begin
			overflow_seen = 1'b1;
		end
		if (req.is_last)
			sort_and_queue();
	endtask

	task automatic check_result(input res_t got);
		res_t want;
		if (sorted_q.size() == 0) begin
			report_mismatch($sformatf("result %0d with nothing pending", got.sorted_value));
		end else begin
			want = sorted_q.pop_front();
			values_checked++;
			if (got.sorted_value !== want.sorted_value)
				report_mismatch($sformatf("sorted_value %0d, want %0d",
					got.sorted_value, want.sorted_value));
			if (got.end_of_set !== want.end_of_set)
				report_mismatch($sformatf("end_of_set %b, want %b on value %0d",
					got.end_of_set, want.end_of_set, want.sorted_value));
			if (got.dropped !== want.dropped)
				report_mismatch($sformatf("dropped %b, want %b on value %0d",
					got.dropped, want.dropped, want.sorted_value));
		end
	endtask

	// Check results before taking the request: a request seen at this edge
	// cannot have produced anything yet.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_count    = 0;
			overflow_seen = 1'b0;
			sorted_q.delete();
			pending <= 0;
		end else begin
			if (result_valid)
				check_result(result);
			if (start && !busy)
				take_request(request);
			pending <= sorted_q.size();
		end
	end

endmodule

@@ test/exchange_sort_buffer_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// exchange_sort_buffer_test: stimulus and verdict for the exchange sort buffer
// Sends directed sets (extreme values, duplicates, a reverse-ordered full set
// with a dropped closing value), then random sets of mixed length, some of
// them overflowing the store. Requests are spaced by random gaps; a separate
// checker predicts and compares every sorted value.
// ----------------------------------------------------------------------------
module exchange_sort_buffer_test;
	import esb_pkg::*;

	localparam int MAX_ITEMS    = 16;
	localparam int RANDOM_ITEMS = 250;
	// Worst quiet stretch is the first scan pass of a full set, ended by its result.
	localparam int IDLE_LIMIT   = 2000;
	localparam int TAIL_CYCLES  = 200;

	localparam logic signed [DATA_W-1:0] MOST_NEG = {1'b1, {(DATA_W-1){1'b0}}};
	localparam logic signed [DATA_W-1:0] MOST_POS = {1'b0, {(DATA_W-1){1'b1}}};

	logic clk     = 1'b0;
	logic arst_n  = 1'b0;
	logic start   = 1'b0;
	req_t request = '0;
	logic busy;
	logic result_valid;
	res_t result;

	int fail_count;
	int pending;
	int sets_closed;
	int sets_dropped;
	int values_checked;
	int items_sent  = 0;
	int idle_cycles = 0;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	exchange_sort_buffer #(
		.MAX_ITEMS(MAX_ITEMS)
	) u_dut (
		.clk,
		.arst_n,
		.start,
		.busy,
		.request,
		.result_valid,
		.result
	);

	exchange_sort_checker #(
		.MAX_ITEMS(MAX_ITEMS)
	) u_checker (
		.clk,
		.arst_n,
		.start,
		.busy,
		.request,
		.result_valid,
		.result,
		.fail_count,
		.pending,
		.sets_closed,
		.sets_dropped,
		.values_checked
	);

	// End the run if neither a request nor a result moves for too long.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_cycles <= 0;
		end else if ((start && !busy) || result_valid) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("watchdog: nothing accepted for %0d cycles", IDLE_LIMIT);
			$display("exchange_sort_buffer_test NOT OK");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// Hold off for a random gap unless told not to, then raise start with the
	// request and keep both steady until an edge with busy low takes them.
	// Busy is read right after the edge, so it is the value the block saw.
	// Start stays high on return, so back-to-back requests never drop it.
	task automatic send_request(input logic signed [DATA_W-1:0] value,
		input logic last, input bit no_idle);
		int   gap;
		req_t req;
		gap              = no_idle ? 0 : $urandom_range(0, 4);
		req.item_value   = value;
		req.is_last      = last;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start   <= 1'b1;
		request <= req;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		items_sent++;
	endtask

	// Mix of extremes, near-extremes, a narrow band that forces duplicates,
	// and full-range random words.
	function automatic logic signed [DATA_W-1:0] pick_value();
		case ($urandom_range(0, 5))
			0: begin
				pick_value = MOST_NEG + $urandom_range(0, 3);
			end
			1: begin
				pick_value = MOST_POS - $urandom_range(0, 3);
			end
			2: begin
				pick_value = $signed($urandom_range(0, 8)) - 4;
			end
			default: begin
				pick_value = $urandom;
			end
		endcase
	endfunction

	initial begin
		int random_goal;
		int set_len;
		bit no_idle;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Single-value sets at both ends of the range.
		send_request(MOST_NEG, 1'b1, 1'b0);
		send_request(MOST_POS, 1'b1, 1'b0);

		// Extremes, zero and repeated values in one set; equal values stay put.
		send_request(MOST_POS, 1'b0, 1'b0);
		send_request(5,        1'b0, 1'b0);
		send_request(MOST_NEG, 1'b0, 1'b0);
		send_request(-3,       1'b0, 1'b0);
		send_request(0,        1'b0, 1'b0);
		send_request(5,        1'b0, 1'b0);
		send_request(-3,       1'b1, 1'b0);

		// Fill the store in descending order, then close with a value that
		// finds it full: it is dropped but still ends the set.
		for (int k = 0; k < MAX_ITEMS; k++)
			send_request(MAX_ITEMS - 1 - k, 1'b0, 1'b1);
		send_request(99, 1'b1, 1'b0);

		// Random sets: mostly short, some exactly full, some overflowing.
		random_goal = items_sent + RANDOM_ITEMS;
		while (items_sent < random_goal) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4, 5: begin
					set_len = $urandom_range(1, 6);
				end
				6, 7: begin
					set_len = $urandom_range(7, MAX_ITEMS);
				end
				8: begin
					set_len = MAX_ITEMS;
				end
				default: begin
					set_len = $urandom_range(MAX_ITEMS + 1, MAX_ITEMS + 4);
				end
			endcase
			no_idle = ($urandom_range(0, 3) == 0);
			for (int k = 0; k < set_len; k++)
				send_request(pick_value(), k == set_len - 1, no_idle);
		end
		start <= 1'b0;

		// Drain: wait for every queued value, then let the block settle.
		do
			@(negedge clk);
		while (pending != 0);
		repeat (TAIL_CYCLES) @(negedge clk);

		$display("Sent %0d requests in %0d sets, %0d of them overflowing the store;",
			items_sent, sets_closed, sets_dropped);
		$display("checked %0d sorted values, %0d mismatches.", values_checked, fail_count);
		if (fail_count == 0 && pending == 0)
			$display("exchange_sort_buffer_test OK");
		else
			$display("exchange_sort_buffer_test NOT OK");
		$finish;
	end

endmodule
